/* rtl/bpd_pkg.sv */
// shared widths, types and fixed-point helpers for the bezier patch derivative core
package bpd_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int PARAM_FRAC_BITS = 16;
   localparam int PARAM_WIDTH     = PARAM_FRAC_BITS + 1;
   localparam int DERIV_WIDTH     = COORD_WIDTH + 4;
   localparam int POINT_COUNT     = 16;
   localparam int INDEX_WIDTH     = $clog2(POINT_COUNT);
   localparam int POINT_BITS      = 3 * COORD_WIDTH;

   // request modes
   localparam logic [1:0] MODE_LOAD    = 2'd0;
   localparam logic [1:0] MODE_DERIV_U = 2'd1;
   localparam logic [1:0] MODE_DERIV_V = 2'd2;
   localparam logic [1:0] MODE_NONE    = 2'd3;

   // evaluated curve point, curve weight and derivative weight widths
   localparam int MID_WIDTH = COORD_WIDTH + 2;
   localparam int CWT_WIDTH = PARAM_FRAC_BITS + 2;
   localparam int DWT_WIDTH = PARAM_FRAC_BITS + 4;

   // shared multiply-accumulate datapath
   localparam int OPA_WIDTH   = (MID_WIDTH > PARAM_WIDTH + 1) ? MID_WIDTH : PARAM_WIDTH + 1;
   localparam int OPB_WIDTH   = DWT_WIDTH;
   localparam int PROD_WIDTH  = OPA_WIDTH + OPB_WIDTH;
   localparam int ACC_WIDTH   = PROD_WIDTH + 2;
   localparam int SUM_WIDTH   = ACC_WIDTH - PARAM_FRAC_BITS;
   localparam int WPROD_WIDTH = 2 * PARAM_FRAC_BITS + 1;

   localparam logic [PARAM_WIDTH-1:0] PARAM_ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};
   localparam int HALF_VALUE = 1 << (PARAM_FRAC_BITS - 1);

   typedef struct packed {
      logic acc;
      logic first;
      logic last;
   } mac_ctl_type;

   typedef struct packed {
      logic                 done;
      logic [SUM_WIDTH-1:0] sum;
   } mac_res_type;

   // round a product of two parameters back to Q1.F
   function automatic logic [PARAM_WIDTH-1:0] rnd_param(input logic [WPROD_WIDTH-1:0] p);
      logic [WPROD_WIDTH:0] s;
      s = {1'b0, p} + (WPROD_WIDTH + 1)'(HALF_VALUE);
      return s[WPROD_WIDTH-1:PARAM_FRAC_BITS];
   endfunction

   function automatic logic [PARAM_WIDTH-1:0] clamp_param(input logic [PARAM_WIDTH-1:0] p);
      return (p > PARAM_ONE) ? PARAM_ONE : p;
   endfunction

   function automatic logic signed [DWT_WIDTH-1:0] triple(input logic [PARAM_WIDTH-1:0] x);
      logic [DWT_WIDTH-1:0] e;
      e = DWT_WIDTH'(x);
      return signed'(e + (e << 1));
   endfunction

endpackage

/* rtl/bpd_ram.sv */
// generic single-port-write, registered-read memory
module bpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bpd_mac.sv */
// one coordinate lane of the shared multiply-accumulate unit with rounded sum
module bpd_mac (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bpd_pkg::mac_ctl_type                   ctl,
   input  logic signed [bpd_pkg::OPA_WIDTH-1:0]   opa,
   input  logic signed [bpd_pkg::OPB_WIDTH-1:0]   opb,
   output logic signed [bpd_pkg::PROD_WIDTH-1:0]  prod,
   output bpd_pkg::mac_res_type                   res
);

   logic signed [bpd_pkg::PROD_WIDTH-1:0] prod_ff;
   logic signed [bpd_pkg::ACC_WIDTH-1:0]  acc_ff, acc_in;
   logic [bpd_pkg::ACC_WIDTH-1:0]         acc_rnd;
   bpd_pkg::mac_ctl_type                  ctl_ff;
   logic                                  done_ff, done_in;

   assign acc_in  = (ctl_ff.first ? '0 : acc_ff) + bpd_pkg::ACC_WIDTH'(prod_ff);
   assign done_in = ctl_ff.acc && ctl_ff.last;

   always_ff @(posedge clock) begin
      prod_ff <= opa * opb;
      if (ctl_ff.acc) begin
         acc_ff <= acc_in;
      end
      if (reset) begin
         ctl_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         ctl_ff  <= ctl;
         done_ff <= done_in;
      end
   end

   // round to nearest, ties upward, then drop the fraction
   assign acc_rnd = acc_ff + bpd_pkg::ACC_WIDTH'(bpd_pkg::HALF_VALUE);

   assign prod     = prod_ff;
   assign res.done = done_ff;
   assign res.sum  = acc_rnd[bpd_pkg::ACC_WIDTH-1:bpd_pkg::PARAM_FRAC_BITS];

endmodule

/* rtl/bezier_patch_partial_derivative_core.sv */
// top level: control point store, weight sequencer and three multiply-accumulate lanes
//
// channel  dir  handshake            beat contents
// req      in   req_valid/req_ready  mode, point_index, coord_x/y/z, param_u/v
// rsp      out  rsp_valid/rsp_ready  deriv_x/y/z
//
// load beats are taken whenever the core is idle; a query beat holds req_ready low from
// accept until its result is registered, so no other beat is taken while it is in flight
// the query time is set by 10 weight steps plus 20 serial multiply-accumulate slots
// on the shared lanes, with pipeline drain between the row and the final pass
// reset clears the sequencer and the response valid; point storage is not cleared
// a stalled response waits in its output register while loads are still taken;
// a query in flight waits at its end for the output register to free up
module bezier_patch_partial_derivative_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [1:0]                              req_mode,
   input  logic [bpd_pkg::INDEX_WIDTH-1:0]         req_point_index,
   input  logic signed [bpd_pkg::COORD_WIDTH-1:0]  req_coord_x,
   input  logic signed [bpd_pkg::COORD_WIDTH-1:0]  req_coord_y,
   input  logic signed [bpd_pkg::COORD_WIDTH-1:0]  req_coord_z,
   input  logic [bpd_pkg::PARAM_WIDTH-1:0]         req_param_u,
   input  logic [bpd_pkg::PARAM_WIDTH-1:0]         req_param_v,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [bpd_pkg::DERIV_WIDTH-1:0]  rsp_deriv_x,
   output logic signed [bpd_pkg::DERIV_WIDTH-1:0]  rsp_deriv_y,
   output logic signed [bpd_pkg::DERIV_WIDTH-1:0]  rsp_deriv_z
);

   localparam logic [3:0] WGT_LAST = 4'd9;
   localparam logic [3:0] ROW_LAST = 4'(bpd_pkg::POINT_COUNT - 1);
   localparam logic [1:0] LAST_K   = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WGT,
      ST_ROWS,
      ST_DRAIN_R,
      ST_MIDS,
      ST_DRAIN_M,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [1:0] mid_cnt_ff, mid_cnt_in;
   logic       along_u_ff, along_u_in;
   logic       meta_vld_ff, meta_vld_in;
   logic [1:0] meta_j_ff, meta_j_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic [bpd_pkg::PARAM_WIDTH-1:0] tc_ff, tc_in, td_ff, td_in, sc, sd;
   logic [bpd_pkg::PARAM_WIDTH-1:0] ssc_ff, ssc_in, tsc_ff, tsc_in;
   logic [bpd_pkg::PARAM_WIDTH-1:0] ssd_ff, ssd_in, tsd_ff, tsd_in, ttd_ff, ttd_in;
   logic signed [bpd_pkg::CWT_WIDTH-1:0] wc_ff [4];
   logic signed [bpd_pkg::CWT_WIDTH-1:0] wc_in [4];
   logic signed [bpd_pkg::DWT_WIDTH-1:0] wd_ff [4];
   logic signed [bpd_pkg::DWT_WIDTH-1:0] wd_in [4];
   logic signed [bpd_pkg::DWT_WIDTH-1:0] ss3, ts3, tt3;

   logic signed [bpd_pkg::MID_WIDTH-1:0] mid_x_ff [4];
   logic signed [bpd_pkg::MID_WIDTH-1:0] mid_x_in [4];
   logic signed [bpd_pkg::MID_WIDTH-1:0] mid_y_ff [4];
   logic signed [bpd_pkg::MID_WIDTH-1:0] mid_y_in [4];
   logic signed [bpd_pkg::MID_WIDTH-1:0] mid_z_ff [4];
   logic signed [bpd_pkg::MID_WIDTH-1:0] mid_z_in [4];

   logic signed [bpd_pkg::DERIV_WIDTH-1:0] deriv_x_ff, deriv_x_in;
   logic signed [bpd_pkg::DERIV_WIDTH-1:0] deriv_y_ff, deriv_y_in;
   logic signed [bpd_pkg::DERIV_WIDTH-1:0] deriv_z_ff, deriv_z_in;

   logic                                  ram_we;
   logic [bpd_pkg::INDEX_WIDTH-1:0]       ram_raddr;
   logic [bpd_pkg::POINT_BITS-1:0]        ram_rdata;
   logic signed [bpd_pkg::COORD_WIDTH-1:0] rd_x, rd_y, rd_z;

   bpd_pkg::mac_ctl_type                   mac_ctl;
   logic signed [bpd_pkg::OPA_WIDTH-1:0]   opa_x, opa_y, opa_z;
   logic signed [bpd_pkg::OPB_WIDTH-1:0]   opb_x, opb_yz;
   logic signed [bpd_pkg::PROD_WIDTH-1:0]  prod_x, prod_y, prod_z;
   bpd_pkg::mac_res_type                   res_x, res_y, res_z;
   logic [bpd_pkg::PARAM_WIDTH-1:0]        wa, wb, wprod;
   logic                                   req_query;

   // point store
   assign ram_we = req_valid && req_ready && (req_mode == bpd_pkg::MODE_LOAD);

   bpd_ram #(
      .WIDTH (bpd_pkg::POINT_BITS),
      .DEPTH (bpd_pkg::POINT_COUNT)
   ) u_points (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_point_index),
      .wr_data ({req_coord_z, req_coord_y, req_coord_x}),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_x = ram_rdata[bpd_pkg::COORD_WIDTH-1:0];
   assign rd_y = ram_rdata[2*bpd_pkg::COORD_WIDTH-1:bpd_pkg::COORD_WIDTH];
   assign rd_z = ram_rdata[3*bpd_pkg::COORD_WIDTH-1:2*bpd_pkg::COORD_WIDTH];

   // along u walks columns, along v walks rows
   assign ram_raddr = along_u_ff ? {cnt_ff[1:0], cnt_ff[3:2]} : cnt_ff;

   assign sc = bpd_pkg::PARAM_ONE - tc_ff;
   assign sd = bpd_pkg::PARAM_ONE - td_ff;

   // weight step operands on the x lane
   always_comb begin
      wa = '0;
      wb = '0;
      unique case (cnt_ff)
         4'd0: begin wa = sc; wb = sc; end
         4'd1: begin wa = tc_ff; wb = sc; end
         4'd2: begin wa = sd; wb = sd; end
         4'd3: begin wa = td_ff; wb = sd; end
         4'd4: begin wa = td_ff; wb = td_ff; end
         4'd5: begin wa = sc; wb = ssc_ff; end
         4'd6: begin wa = sc; wb = tsc_ff; end
         4'd7: begin wa = tc_ff; wb = tsc_ff; end
         default: begin wa = '0; wb = '0; end
      endcase
   end

   assign wprod = bpd_pkg::rnd_param(prod_x[bpd_pkg::WPROD_WIDTH-1:0]);

   always_comb begin
      mac_ctl = '0;
      opa_x   = bpd_pkg::OPA_WIDTH'(wa);
      opa_y   = '0;
      opa_z   = '0;
      opb_x   = bpd_pkg::OPB_WIDTH'(wb);
      opb_yz  = '0;
      priority if (meta_vld_ff) begin
         mac_ctl.acc   = 1'b1;
         mac_ctl.first = (meta_j_ff == 2'd0);
         mac_ctl.last  = (meta_j_ff == LAST_K);
         opa_x  = bpd_pkg::OPA_WIDTH'(rd_x);
         opa_y  = bpd_pkg::OPA_WIDTH'(rd_y);
         opa_z  = bpd_pkg::OPA_WIDTH'(rd_z);
         opb_x  = bpd_pkg::OPB_WIDTH'(wc_ff[meta_j_ff]);
         opb_yz = bpd_pkg::OPB_WIDTH'(wc_ff[meta_j_ff]);
      end else if (state_ff == ST_MIDS) begin
         mac_ctl.acc   = 1'b1;
         mac_ctl.first = (cnt_ff[1:0] == 2'd0);
         mac_ctl.last  = (cnt_ff[1:0] == LAST_K);
         opa_x  = bpd_pkg::OPA_WIDTH'(mid_x_ff[cnt_ff[1:0]]);
         opa_y  = bpd_pkg::OPA_WIDTH'(mid_y_ff[cnt_ff[1:0]]);
         opa_z  = bpd_pkg::OPA_WIDTH'(mid_z_ff[cnt_ff[1:0]]);
         opb_x  = wd_ff[cnt_ff[1:0]];
         opb_yz = wd_ff[cnt_ff[1:0]];
      end else begin
         mac_ctl = '0;
      end
   end

   bpd_mac u_mac_x (
      .clock (clock), .reset (reset), .ctl (mac_ctl),
      .opa (opa_x), .opb (opb_x), .prod (prod_x), .res (res_x)
   );

   bpd_mac u_mac_y (
      .clock (clock), .reset (reset), .ctl (mac_ctl),
      .opa (opa_y), .opb (opb_yz), .prod (prod_y), .res (res_y)
   );

   bpd_mac u_mac_z (
      .clock (clock), .reset (reset), .ctl (mac_ctl),
      .opa (opa_z), .opb (opb_yz), .prod (prod_z), .res (res_z)
   );

   assign ss3 = bpd_pkg::triple(ssd_ff);
   assign ts3 = bpd_pkg::triple(tsd_ff);
   assign tt3 = bpd_pkg::triple(ttd_ff);

   assign req_query = (req_mode == bpd_pkg::MODE_DERIV_U) ||
                      (req_mode == bpd_pkg::MODE_DERIV_V);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      mid_cnt_in   = mid_cnt_ff;
      along_u_in   = along_u_ff;
      meta_vld_in  = 1'b0;
      meta_j_in    = cnt_ff[1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      tc_in        = tc_ff;
      td_in        = td_ff;
      ssc_in       = ssc_ff;
      tsc_in       = tsc_ff;
      ssd_in       = ssd_ff;
      tsd_in       = tsd_ff;
      ttd_in       = ttd_ff;
      wc_in        = wc_ff;
      wd_in        = wd_ff;
      mid_x_in     = mid_x_ff;
      mid_y_in     = mid_y_ff;
      mid_z_in     = mid_z_ff;
      deriv_x_in   = deriv_x_ff;
      deriv_y_in   = deriv_y_ff;
      deriv_z_in   = deriv_z_ff;

      // evaluated curve points arrive while rows are still being read
      if (res_x.done && (state_ff == ST_ROWS || state_ff == ST_DRAIN_R)) begin
         mid_x_in[mid_cnt_ff] = res_x.sum[bpd_pkg::MID_WIDTH-1:0];
         mid_y_in[mid_cnt_ff] = res_y.sum[bpd_pkg::MID_WIDTH-1:0];
         mid_z_in[mid_cnt_ff] = res_z.sum[bpd_pkg::MID_WIDTH-1:0];
         mid_cnt_in = mid_cnt_ff + 2'd1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_query) begin
               along_u_in = (req_mode == bpd_pkg::MODE_DERIV_U);
               tc_in = bpd_pkg::clamp_param((req_mode == bpd_pkg::MODE_DERIV_U) ? req_param_v
                                                                                : req_param_u);
               td_in = bpd_pkg::clamp_param((req_mode == bpd_pkg::MODE_DERIV_U) ? req_param_u
                                                                                : req_param_v);
               cnt_in   = '0;
               state_in = ST_WGT;
            end
         end
         ST_WGT: begin
            cnt_in = cnt_ff + 4'd1;
            unique case (cnt_ff)
               4'd1: ssc_in = wprod;
               4'd2: tsc_in = wprod;
               4'd3: ssd_in = wprod;
               4'd4: tsd_in = wprod;
               4'd5: ttd_in = wprod;
               4'd6: wc_in[0] = bpd_pkg::CWT_WIDTH'(wprod);
               4'd7: wc_in[1] = bpd_pkg::CWT_WIDTH'(bpd_pkg::triple(wprod));
               4'd8: wc_in[2] = bpd_pkg::CWT_WIDTH'(bpd_pkg::triple(wprod));
               WGT_LAST: begin
                  wc_in[3] = signed'(bpd_pkg::CWT_WIDTH'(bpd_pkg::PARAM_ONE))
                             - wc_ff[0] - wc_ff[1] - wc_ff[2];
                  wd_in[0] = -ss3;
                  wd_in[1] = ss3 - (ts3 <<< 1);
                  wd_in[2] = (ts3 <<< 1) - tt3;
                  wd_in[3] = tt3;
                  cnt_in     = '0;
                  mid_cnt_in = '0;
                  state_in   = ST_ROWS;
               end
               default: ;
            endcase
         end
         ST_ROWS: begin
            meta_vld_in = 1'b1;
            cnt_in      = cnt_ff + 4'd1;
            if (cnt_ff == ROW_LAST) begin
               state_in = ST_DRAIN_R;
            end
         end
         ST_DRAIN_R: begin
            if (res_x.done && mid_cnt_ff == LAST_K) begin
               cnt_in   = '0;
               state_in = ST_MIDS;
            end
         end
         ST_MIDS: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff[1:0] == LAST_K) begin
               cnt_in   = '0;
               state_in = ST_DRAIN_M;
            end
         end
         ST_DRAIN_M: begin
            if (res_x.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               deriv_x_in   = res_x.sum[bpd_pkg::DERIV_WIDTH-1:0];
               deriv_y_in   = res_y.sum[bpd_pkg::DERIV_WIDTH-1:0];
               deriv_z_in   = res_z.sum[bpd_pkg::DERIV_WIDTH-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      mid_cnt_ff <= mid_cnt_in;
      along_u_ff <= along_u_in;
      meta_j_ff  <= meta_j_in;
      tc_ff      <= tc_in;
      td_ff      <= td_in;
      ssc_ff     <= ssc_in;
      tsc_ff     <= tsc_in;
      ssd_ff     <= ssd_in;
      tsd_ff     <= tsd_in;
      ttd_ff     <= ttd_in;
      wc_ff      <= wc_in;
      wd_ff      <= wd_in;
      mid_x_ff   <= mid_x_in;
      mid_y_ff   <= mid_y_in;
      mid_z_ff   <= mid_z_in;
      deriv_x_ff <= deriv_x_in;
      deriv_y_ff <= deriv_y_in;
      deriv_z_ff <= deriv_z_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         meta_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         meta_vld_ff  <= meta_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_deriv_x = deriv_x_ff;
   assign rsp_deriv_y = deriv_y_ff;
   assign rsp_deriv_z = deriv_z_ff;

   a_lanes_in_step: assert property (@(posedge clock) disable iff (reset)
      (res_x.done == res_y.done) && (res_x.done == res_z.done))
      else $error("coordinate lanes out of step");

   a_done_in_pass: assert property (@(posedge clock) disable iff (reset)
      res_x.done |-> (state_ff == ST_ROWS || state_ff == ST_DRAIN_R || state_ff == ST_DRAIN_M))
      else $error("lane sum completed outside a pass");

   a_read_from_rows: assert property (@(posedge clock) disable iff (reset)
      meta_vld_ff |-> $past(state_ff == ST_ROWS))
      else $error("point beat without a row read");

   a_mids_complete: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIDS && cnt_ff == 4'd0) |-> (mid_cnt_ff == 2'd0))
      else $error("final pass started before all curve points were captured");

   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_FIN))
      else $error("finished query lost while output register busy");

endmodule

/* verif/bezier_patch_partial_derivative_core_tb.sv */
// self-checking testbench for the bezier patch partial derivative core
module bezier_patch_partial_derivative_core_tb;

   localparam int CW = bpd_pkg::COORD_WIDTH;
   localparam int DW = bpd_pkg::DERIV_WIDTH;
   localparam int PW = bpd_pkg::PARAM_WIDTH;
   localparam int IW = bpd_pkg::INDEX_WIDTH;
   localparam int FRAC = bpd_pkg::PARAM_FRAC_BITS;
   localparam int SLOTS = bpd_pkg::POINT_COUNT;
   localparam int PONE = 1 << FRAC;
   localparam longint HALF = longint'(1) << (FRAC - 1);
   localparam int RANDOM_ITEMS = 1726;
   localparam int HOLD_CYCLES = 500;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT = 1000000;

   typedef enum logic [1:0] {
      OP_LOAD    = bpd_pkg::MODE_LOAD,
      OP_ALONG_U = bpd_pkg::MODE_DERIV_U,
      OP_ALONG_V = bpd_pkg::MODE_DERIV_V,
      OP_IDLE    = bpd_pkg::MODE_NONE
   } patch_op_type;

   typedef struct packed {
      patch_op_type           mode;
      logic [IW-1:0]          index;
      logic [2:0][CW-1:0]     coord;
      logic [PW-1:0]          pu;
      logic [PW-1:0]          pv;
   } patch_beat_type;

   typedef logic [2:0][DW-1:0] deriv_set_type;
   typedef longint weight_set_type [4];

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_mode = '0;
   logic [IW-1:0] req_point_index = '0;
   logic signed [CW-1:0] req_coord_x = '0;
   logic signed [CW-1:0] req_coord_y = '0;
   logic signed [CW-1:0] req_coord_z = '0;
   logic [PW-1:0] req_param_u = '0;
   logic [PW-1:0] req_param_v = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [DW-1:0] rsp_deriv_x;
   logic signed [DW-1:0] rsp_deriv_y;
   logic signed [DW-1:0] rsp_deriv_z;

   patch_beat_type pending_beats[$];
   deriv_set_type expected_derivs[$];
   longint patch_ctrl [3][SLOTS];

   patch_beat_type cur_beat;
   deriv_set_type want_derivs, got_derivs;
   int send_wait = 0, send_calm = 0, take_wait = 0, take_calm = 0;
   int beats_taken = 0, total_beats = 0, error_count = 0, cycle_count = 0;
   int hold_marks [2] = '{300, 1100};
   logic long_hold = 1'b0;

   bezier_patch_partial_derivative_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_point_index(req_point_index),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_coord_z    (req_coord_z),
      .req_param_u    (req_param_u),
      .req_param_v    (req_param_v),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_deriv_x    (rsp_deriv_x),
      .rsp_deriv_y    (rsp_deriv_y),
      .rsp_deriv_z    (rsp_deriv_z)
   );

   initial forever #5 clock = ~clock;

   function automatic longint frac_round(input longint x);
      return (x + HALF) >>> FRAC;
   endfunction

   function automatic longint clip_param(input logic [PW-1:0] p);
      return (p > PW'(PONE)) ? longint'(PONE) : longint'(p);
   endfunction

   function automatic void bernstein_weights(input longint t, output weight_set_type w);
      longint s, ss, ts;
      s = PONE - t;
      ss = frac_round(s * s);
      ts = frac_round(t * s);
      w[0] = frac_round(s * ss);
      w[1] = 3 * frac_round(s * ts);
      w[2] = 3 * frac_round(t * ts);
      w[3] = PONE - w[0] - w[1] - w[2];
   endfunction

   function automatic void slope_weights(input longint t, output weight_set_type w);
      longint s, ss, ts, tt;
      s = PONE - t;
      ss = frac_round(s * s);
      ts = frac_round(t * s);
      tt = frac_round(t * t);
      w[0] = -3 * ss;
      w[1] = 3 * ss - 6 * ts;
      w[2] = 6 * ts - 3 * tt;
      w[3] = 3 * tt;
   endfunction

   function automatic longint blend4(input weight_set_type c, input weight_set_type w);
      longint acc;
      acc = 0;
      for (int k = 0; k < 4; k++) acc += c[k] * w[k];
      return frac_round(acc);
   endfunction

   // updates the stored patch or queues the derivative a query should return
   function automatic void track_patch_beat(input patch_beat_type b);
      longint t_cross, t_run;
      weight_set_type wc, wd, pts, mid;
      deriv_set_type want;
      int c, k, j;
      case (b.mode)
         OP_LOAD: begin
            for (c = 0; c < 3; c++)
               patch_ctrl[c][b.index] = longint'($signed(b.coord[c]));
         end
         OP_ALONG_U, OP_ALONG_V: begin
            if (b.mode == OP_ALONG_U) begin
               t_cross = clip_param(b.pv);
               t_run = clip_param(b.pu);
            end else begin
               t_cross = clip_param(b.pu);
               t_run = clip_param(b.pv);
            end
            bernstein_weights(t_cross, wc);
            slope_weights(t_run, wd);
            for (c = 0; c < 3; c++) begin
               for (k = 0; k < 4; k++) begin
                  for (j = 0; j < 4; j++)
                     pts[j] = (b.mode == OP_ALONG_U) ? patch_ctrl[c][j*4+k]
                                                     : patch_ctrl[c][k*4+j];
                  mid[k] = blend4(pts, wc);
               end
               want[c] = DW'(blend4(mid, wd));
            end
            expected_derivs.push_back(want);
         end
         default: ;
      endcase
   endfunction

   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm = int'($urandom_range(20, 80));
         return 0;
      end
      return int'($urandom_range(0, 12));
   endfunction

   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return {1'b0, {(CW-1){1'b1}}};
         1: return {1'b1, {(CW-1){1'b0}}};
         2, 3, 4: return CW'($urandom_range(0, 2097151)) - CW'(1048576);
         default: return CW'($urandom);
      endcase
   endfunction

   function automatic logic [PW-1:0] rand_param();
      case ($urandom_range(0, 11))
         0: return '0;
         1: return PW'(PONE);
         2: return PW'($urandom_range(PONE + 1, (1 << PW) - 1));
         3: return PW'($urandom_range(0, 255));
         4: return PW'($urandom_range(PONE - 256, PONE));
         default: return PW'($urandom_range(0, PONE));
      endcase
   endfunction

   function automatic void queue_load(input int idx, input logic [CW-1:0] x,
                                      input logic [CW-1:0] y, input logic [CW-1:0] z);
      patch_beat_type b;
      b.mode = OP_LOAD;
      b.index = IW'(idx);
      b.coord = {z, y, x};
      b.pu = PW'($urandom);
      b.pv = PW'($urandom);
      pending_beats.push_back(b);
   endfunction

   function automatic void queue_query(input patch_op_type op, input logic [PW-1:0] u,
                                       input logic [PW-1:0] v);
      patch_beat_type b;
      b.mode = op;
      b.index = IW'($urandom);
      b.coord = {CW'($urandom), CW'($urandom), CW'($urandom)};
      b.pu = u;
      b.pv = v;
      pending_beats.push_back(b);
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_valid && req_ready) begin
            track_patch_beat(cur_beat);
            beats_taken <= beats_taken + 1;
            send_wait = draw_gap(send_calm);
         end
         if (!req_valid || req_ready) begin
            if (send_wait > 0 || pending_beats.size() == 0) begin
               if (send_wait > 0) send_wait--;
               req_valid <= 1'b0;
            end else begin
               cur_beat = pending_beats.pop_front();
               req_mode <= cur_beat.mode;
               req_point_index <= cur_beat.index;
               req_coord_x <= cur_beat.coord[0];
               req_coord_y <= cur_beat.coord[1];
               req_coord_z <= cur_beat.coord[2];
               req_param_u <= cur_beat.pu;
               req_param_v <= cur_beat.pv;
               req_valid <= 1'b1;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         take_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_derivs = {rsp_deriv_z, rsp_deriv_y, rsp_deriv_x};
            if (expected_derivs.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected result beat at cycle %0d: x=%0d y=%0d z=%0d",
                           cycle_count, rsp_deriv_x, rsp_deriv_y, rsp_deriv_z);
               error_count++;
            end else begin
               want_derivs = expected_derivs.pop_front();
               for (int c = 0; c < 3; c++) begin
                  if (got_derivs[c] !== want_derivs[c]) begin
                     if (error_count < 10)
                        $display("deriv_%s mismatch at cycle %0d: expected %0d, got %0d",
                                 c == 0 ? "x" : c == 1 ? "y" : "z", cycle_count,
                                 $signed(want_derivs[c]), $signed(got_derivs[c]));
                     error_count++;
                  end
               end
            end
            take_wait = draw_gap(take_calm);
         end
         rsp_ready <= (take_wait == 0) && !long_hold;
         if (take_wait > 0) take_wait--;
      end
   end

   // long receiver stall so the core backs up and stops taking beats
   initial begin
      foreach (hold_marks[i]) begin
         while (beats_taken < hold_marks[i]) @(posedge clock);
         long_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         long_hold <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int counted, pick;
      logic [CW-1:0] z_val;

      // every slot written first, with extreme x and y coordinates
      for (int i = 0; i < SLOTS; i++) begin
         case (i % 4)
            0: z_val = '0;
            1: z_val = '1;
            2: z_val = CW'(1);
            default: z_val = CW'($urandom);
         endcase
         queue_load(i, (i % 2 == 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}},
                    (i < 8) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}}, z_val);
      end
      queue_query(OP_ALONG_U, '0, '0);
      queue_query(OP_ALONG_V, '0, '0);
      queue_query(OP_ALONG_U, PW'(PONE), PW'(PONE));
      queue_query(OP_ALONG_V, PW'(PONE), PW'(PONE));
      queue_query(OP_ALONG_U, '1, PW'(PONE + 1));
      queue_query(OP_ALONG_V, PW'(PONE / 2), PW'(PONE + 1));
      queue_query(OP_IDLE, PW'($urandom), PW'($urandom));
      queue_query(OP_ALONG_U, PW'(1), PW'(PONE - 1));

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         pick = int'($urandom_range(0, 99));
         if (pick < 4) begin
            queue_query(OP_IDLE, PW'($urandom), PW'($urandom));
         end else if (pick < 8) begin
            for (int i = 0; i < SLOTS; i++)
               queue_load(i, rand_coord(), rand_coord(), rand_coord());
            counted += SLOTS;
         end else if (pick < 50) begin
            queue_load(int'($urandom_range(0, SLOTS - 1)), rand_coord(), rand_coord(),
                       rand_coord());
            counted++;
         end else begin
            if ($urandom_range(0, 1) == 0) queue_query(OP_ALONG_U, rand_param(), rand_param());
            else queue_query(OP_ALONG_V, rand_param(), rand_param());
            counted++;
         end
      end
      total_beats = pending_beats.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (beats_taken < total_beats || expected_derivs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      error_count += expected_derivs.size();
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* files.f */
rtl/bpd_pkg.sv
rtl/bpd_ram.sv
rtl/bpd_mac.sv
rtl/bezier_patch_partial_derivative_core.sv
verif/bezier_patch_partial_derivative_core_tb.sv
